FILE: hdl/slpc_pkg.sv
// Shared types, constants and status presets for the status LED pattern controller.
package slpc_pkg;

    localparam int KIND_W   = 3;
    localparam int CODE_W   = 3;
    localparam int LEVEL_W  = 8;
    localparam int TIME_W   = 16;
    localparam int SEG_W    = 3;
    localparam int OTMR_W   = 11;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_STATUS  = 3'd1,
        KIND_SUCCESS = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_BLINK   = 3'd4,
        KIND_COLOR   = 3'd5,
        KIND_OFF     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_SOLID = 2'd1,
        MODE_BLINK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OVR_NONE    = 2'd0,
        OVR_SUCCESS = 2'd1,
        OVR_ERROR   = 2'd2
    } ovr_t;

    localparam logic [CODE_W-1:0] ST_AP         = 3'd0;
    localparam logic [CODE_W-1:0] ST_CONNECTING = 3'd1;
    localparam logic [CODE_W-1:0] ST_NORMAL     = 3'd2;
    localparam logic [CODE_W-1:0] ST_REQUEST    = 3'd3;
    localparam logic [CODE_W-1:0] ST_RESET_WARN = 3'd4;
    localparam logic [CODE_W-1:0] ST_FACTORY    = 3'd5;

    localparam logic [LEVEL_W-1:0] FLASH_LEVEL = 8'd40;
    localparam logic [OTMR_W-1:0]  SHORT_MS    = 11'd100;
    localparam logic [OTMR_W-1:0]  LONG_MS     = 11'd1000;
    localparam logic [OTMR_W-1:0]  ERR_SEG_MS  = 11'd200;

    typedef struct packed {
        logic                 valid;
        mode_t                mode;
        logic [LEVEL_W-1:0]   red;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   blue;
        logic [TIME_W-1:0]    on_ms;
        logic [TIME_W-1:0]    off_ms;
    } preset_t;

    function automatic preset_t status_preset(input logic [CODE_W-1:0] code);
        preset_t p;
        p = '{valid: 1'b0, mode: MODE_OFF, red: '0, green: '0, blue: '0,
              on_ms: '0, off_ms: '0};
        unique case (code)
            ST_AP:         p = '{1'b1, MODE_BLINK, 8'd0, 8'd0, 8'd30, 16'd1000, 16'd1000};
            ST_CONNECTING: p = '{1'b1, MODE_BLINK, 8'd30, 8'd20, 8'd0, 16'd200, 16'd200};
            ST_NORMAL:     p = '{1'b1, MODE_SOLID, 8'd0, 8'd25, 8'd0, 16'd0, 16'd0};
            ST_REQUEST:    p = '{1'b1, MODE_BLINK, 8'd0, 8'd20, 8'd30, 16'd150, 16'd150};
            ST_RESET_WARN: p = '{1'b1, MODE_BLINK, 8'd40, 8'd0, 8'd0, 16'd100, 16'd100};
            ST_FACTORY:    p = '{1'b1, MODE_SOLID, 8'd40, 8'd0, 8'd0, 16'd0, 16'd0};
            default: p.valid = 1'b0;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/slpc_if.sv
// Command and LED result channel interfaces for the status LED pattern controller.
interface slpc_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [slpc_pkg::KIND_W-1:0]    kind;
    logic [slpc_pkg::CODE_W-1:0]    status_code;
    logic [slpc_pkg::LEVEL_W-1:0]   red_in;
    logic [slpc_pkg::LEVEL_W-1:0]   green_in;
    logic [slpc_pkg::LEVEL_W-1:0]   blue_in;
    logic [slpc_pkg::TIME_W-1:0]    on_time;
    logic [slpc_pkg::TIME_W-1:0]    off_time;

    modport source (output valid, kind, status_code, red_in, green_in, blue_in,
                    on_time, off_time, input ready);
    modport sink   (input valid, kind, status_code, red_in, green_in, blue_in,
                    on_time, off_time, output ready);
endinterface

interface slpc_led_if;
    logic                           valid;
    logic                           ready;
    logic [slpc_pkg::LEVEL_W-1:0]   red_out;
    logic [slpc_pkg::LEVEL_W-1:0]   green_out;
    logic [slpc_pkg::LEVEL_W-1:0]   blue_out;
    logic                           override_busy;

    modport source (output valid, red_out, green_out, blue_out, override_busy,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, override_busy,
                    output ready);
endinterface

FILE: hdl/status_led_pattern_controller_core.sv
// Top level of the status LED pattern controller: pattern state, override sequencer and output.
//
// The cmd channel carries one transaction per event: a 1 ms tick, a status
// code, a success or error signal, a blink time setting, a color setting or
// an off command. For every accepted cmd transaction exactly one transaction
// appears on the led channel, holding the color shown after that event and
// a flag that is high while a success or error sequence is showing.
// The state update and the shown color are computed in the accepting cycle
// and the result register presents them on the next. Throughput is one
// transaction per cycle while led.ready is high; the single result register
// sets that figure. cmd.ready is high whenever the result register is empty
// or is being emptied in the same cycle, so a stalled receiver holds the
// result and pauses the cmd channel without losing or repeating anything.
// Reset clears the pattern to off, cancels any override and empties the
// result register. ERROR_FLASHES sets the number of red flashes of the error
// sequence (1 to 8).
module status_led_pattern_controller_core #(
    parameter int ERROR_FLASHES = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    slpc_cmd_if.sink      cmd,
    slpc_led_if.source    led
);

    localparam logic [slpc_pkg::SEG_W-1:0] ErrLast = slpc_pkg::SEG_W'(ERROR_FLASHES - 1);

    slpc_pkg::mode_t                  mode_reg, mode_next;
    logic [slpc_pkg::LEVEL_W-1:0]     pat_red_reg, pat_red_next;
    logic [slpc_pkg::LEVEL_W-1:0]     pat_green_reg, pat_green_next;
    logic [slpc_pkg::LEVEL_W-1:0]     pat_blue_reg, pat_blue_next;
    logic [slpc_pkg::TIME_W-1:0]      on_dur_reg, on_dur_next;
    logic [slpc_pkg::TIME_W-1:0]      off_dur_reg, off_dur_next;
    logic                             off_phase_reg, off_phase_next;
    logic [slpc_pkg::TIME_W-1:0]      phase_tmr_reg, phase_tmr_next;
    slpc_pkg::ovr_t                   ovr_kind_reg, ovr_kind_next;
    logic [slpc_pkg::SEG_W-1:0]       ovr_seg_reg, ovr_seg_next;
    logic [slpc_pkg::OTMR_W-1:0]      ovr_tmr_reg, ovr_tmr_next;

    logic                             out_valid_reg;
    logic [slpc_pkg::LEVEL_W-1:0]     out_red_reg, out_red_next;
    logic [slpc_pkg::LEVEL_W-1:0]     out_green_reg, out_green_next;
    logic [slpc_pkg::LEVEL_W-1:0]     out_blue_reg, out_blue_next;
    logic                             out_busy_reg;

    logic                             accept;
    slpc_pkg::preset_t                preset;
    logic [slpc_pkg::OTMR_W-1:0]      ovr_limit;
    logic [slpc_pkg::SEG_W-1:0]       ovr_last;
    logic [slpc_pkg::OTMR_W-1:0]      ovr_tmr_inc;
    logic [slpc_pkg::TIME_W:0]        phase_inc;
    logic [slpc_pkg::TIME_W-1:0]      phase_dur;

    assign cmd.ready = !out_valid_reg || led.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign preset    = slpc_pkg::status_preset(cmd.status_code);

    assign ovr_limit   = (ovr_kind_reg == slpc_pkg::OVR_SUCCESS)
                         ? ((ovr_seg_reg == '0) ? slpc_pkg::SHORT_MS : slpc_pkg::LONG_MS)
                         : slpc_pkg::ERR_SEG_MS;
    assign ovr_last    = (ovr_kind_reg == slpc_pkg::OVR_SUCCESS)
                         ? slpc_pkg::SEG_W'(1) : ErrLast;
    assign ovr_tmr_inc = ovr_tmr_reg + 1'b1;
    assign phase_dur   = off_phase_reg ? off_dur_reg : on_dur_reg;
    assign phase_inc   = {1'b0, phase_tmr_reg} + 1'b1;

    always_comb
    begin
        mode_next      = mode_reg;
        pat_red_next   = pat_red_reg;
        pat_green_next = pat_green_reg;
        pat_blue_next  = pat_blue_reg;
        on_dur_next    = on_dur_reg;
        off_dur_next   = off_dur_reg;
        off_phase_next = off_phase_reg;
        phase_tmr_next = phase_tmr_reg;
        ovr_kind_next  = ovr_kind_reg;
        ovr_seg_next   = ovr_seg_reg;
        ovr_tmr_next   = ovr_tmr_reg;

        unique case (slpc_pkg::kind_t'(cmd.kind))
            slpc_pkg::KIND_TICK:
            begin
                if (ovr_kind_reg != slpc_pkg::OVR_NONE)
                begin
                    if (ovr_tmr_inc >= ovr_limit)
                    begin
                        ovr_tmr_next = '0;
                        if (ovr_seg_reg >= ovr_last)
                        begin
                            ovr_kind_next  = slpc_pkg::OVR_NONE;
                            ovr_seg_next   = '0;
                            off_phase_next = 1'b0;
                            phase_tmr_next = '0;
                        end
                        else
                        begin
                            ovr_seg_next = ovr_seg_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ovr_tmr_next = ovr_tmr_inc;
                    end
                end
                else if (mode_reg == slpc_pkg::MODE_BLINK && on_dur_reg != '0
                         && off_dur_reg != '0)
                begin
                    if (phase_inc >= {1'b0, phase_dur})
                    begin
                        phase_tmr_next = '0;
                        off_phase_next = !off_phase_reg;
                    end
                    else
                    begin
                        phase_tmr_next = phase_inc[slpc_pkg::TIME_W-1:0];
                    end
                end
            end
            slpc_pkg::KIND_STATUS:
            begin
                if (preset.valid)
                begin
                    mode_next      = preset.mode;
                    pat_red_next   = preset.red;
                    pat_green_next = preset.green;
                    pat_blue_next  = preset.blue;
                    on_dur_next    = preset.on_ms;
                    off_dur_next   = preset.off_ms;
                end
                off_phase_next = 1'b0;
                phase_tmr_next = '0;
            end
            slpc_pkg::KIND_SUCCESS:
            begin
                ovr_kind_next = slpc_pkg::OVR_SUCCESS;
                ovr_seg_next  = '0;
                ovr_tmr_next  = '0;
            end
            slpc_pkg::KIND_ERROR:
            begin
                ovr_kind_next = slpc_pkg::OVR_ERROR;
                ovr_seg_next  = '0;
                ovr_tmr_next  = '0;
            end
            slpc_pkg::KIND_BLINK:
            begin
                mode_next      = slpc_pkg::MODE_BLINK;
                on_dur_next    = cmd.on_time;
                off_dur_next   = cmd.off_time;
                off_phase_next = 1'b0;
                phase_tmr_next = '0;
            end
            slpc_pkg::KIND_COLOR:
            begin
                mode_next      = slpc_pkg::MODE_SOLID;
                pat_red_next   = cmd.red_in;
                pat_green_next = cmd.green_in;
                pat_blue_next  = cmd.blue_in;
                on_dur_next    = '0;
                off_dur_next   = '0;
                off_phase_next = 1'b0;
                phase_tmr_next = '0;
            end
            slpc_pkg::KIND_OFF:
            begin
                mode_next      = slpc_pkg::MODE_OFF;
                pat_red_next   = '0;
                pat_green_next = '0;
                pat_blue_next  = '0;
                on_dur_next    = '0;
                off_dur_next   = '0;
                off_phase_next = 1'b0;
                phase_tmr_next = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb
    begin
        out_red_next   = '0;
        out_green_next = '0;
        out_blue_next  = '0;
        priority if (ovr_kind_next == slpc_pkg::OVR_SUCCESS)
        begin
            if (ovr_seg_next != '0)
            begin
                out_green_next = slpc_pkg::FLASH_LEVEL;
            end
        end
        else if (ovr_kind_next == slpc_pkg::OVR_ERROR)
        begin
            if (ovr_tmr_next < slpc_pkg::SHORT_MS)
            begin
                out_red_next = slpc_pkg::FLASH_LEVEL;
            end
        end
        else if (mode_next == slpc_pkg::MODE_SOLID
                 || (mode_next == slpc_pkg::MODE_BLINK && on_dur_next != '0
                     && (off_dur_next == '0 || !off_phase_next)))
        begin
            out_red_next   = pat_red_next;
            out_green_next = pat_green_next;
            out_blue_next  = pat_blue_next;
        end
        else
        begin
            out_red_next   = '0;
            out_green_next = '0;
            out_blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= slpc_pkg::MODE_OFF;
            pat_red_reg   <= '0;
            pat_green_reg <= '0;
            pat_blue_reg  <= '0;
            on_dur_reg    <= '0;
            off_dur_reg   <= '0;
            off_phase_reg <= 1'b0;
            phase_tmr_reg <= '0;
            ovr_kind_reg  <= slpc_pkg::OVR_NONE;
            ovr_seg_reg   <= '0;
            ovr_tmr_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_busy_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                pat_red_reg   <= pat_red_next;
                pat_green_reg <= pat_green_next;
                pat_blue_reg  <= pat_blue_next;
                on_dur_reg    <= on_dur_next;
                off_dur_reg   <= off_dur_next;
                off_phase_reg <= off_phase_next;
                phase_tmr_reg <= phase_tmr_next;
                ovr_kind_reg  <= ovr_kind_next;
                ovr_seg_reg   <= ovr_seg_next;
                ovr_tmr_reg   <= ovr_tmr_next;
                out_busy_reg  <= (ovr_kind_next != slpc_pkg::OVR_NONE);
                out_valid_reg <= 1'b1;
            end
            else if (led.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
        end
    end

    assign led.valid         = out_valid_reg;
    assign led.red_out       = out_red_reg;
    assign led.green_out     = out_green_reg;
    assign led.blue_out      = out_blue_reg;
    assign led.override_busy = out_busy_reg;

`ifndef NO_ASSERTIONS
    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (led.override_busy == (ovr_kind_reg != slpc_pkg::OVR_NONE)))
        else $error("override_busy disagrees with the override state");

    a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (led.valid && !led.ready) |-> !cmd.ready)
        else $error("command accepted while a result transaction is stalled");

    a_success_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (ovr_kind_reg == slpc_pkg::OVR_SUCCESS)
        |-> (ovr_seg_reg <= 3'd1 && ovr_tmr_reg < slpc_pkg::LONG_MS))
        else $error("success sequence segment or timer out of range");

    a_error_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (ovr_kind_reg == slpc_pkg::OVR_ERROR)
        |-> (ovr_seg_reg <= ErrLast && ovr_tmr_reg < slpc_pkg::ERR_SEG_MS))
        else $error("error sequence segment or timer out of range");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == slpc_pkg::MODE_BLINK && on_dur_reg != '0 && off_dur_reg != '0)
        |-> (phase_tmr_reg < phase_dur))
        else $error("blink phase timer passed its phase length");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the status LED pattern controller with its own LED state predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int N_FLASHES      = 3;
    localparam int PER_PHASE      = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 5;

    localparam logic [slpc_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [slpc_pkg::KIND_W-1:0]  kind;
        logic [slpc_pkg::CODE_W-1:0]  code;
        logic [slpc_pkg::LEVEL_W-1:0] red;
        logic [slpc_pkg::LEVEL_W-1:0] green;
        logic [slpc_pkg::LEVEL_W-1:0] blue;
        logic [slpc_pkg::TIME_W-1:0]  on_ms;
        logic [slpc_pkg::TIME_W-1:0]  off_ms;
    } cmd_t;

    typedef struct packed {
        logic [slpc_pkg::LEVEL_W-1:0] red;
        logic [slpc_pkg::LEVEL_W-1:0] green;
        logic [slpc_pkg::LEVEL_W-1:0] blue;
        logic                         busy;
    } led_result_t;

    class led_state_tracker;
        slpc_pkg::mode_t              mode;
        logic [slpc_pkg::LEVEL_W-1:0] red, green, blue;
        logic [slpc_pkg::TIME_W-1:0]  on_ms, off_ms;
        bit                           off_phase;
        int unsigned                  phase_ms;
        slpc_pkg::ovr_t               ovr;
        int unsigned                  seg;
        int unsigned                  ovr_ms;
        led_result_t                  shown_q[$];
        int                           cmds_seen;
        int                           checked;
        int                           mismatches;
        int                           overrides_done;
        int                           phase_flips;

        function new();
            set_pattern(slpc_pkg::MODE_OFF, 0, 0, 0, 0, 0);
            restart_blink();
            ovr            = slpc_pkg::OVR_NONE;
            seg            = 0;
            ovr_ms         = 0;
            cmds_seen      = 0;
            checked        = 0;
            mismatches     = 0;
            overrides_done = 0;
            phase_flips    = 0;
        endfunction

        function void restart_blink();
            off_phase = 1'b0;
            phase_ms  = 0;
        endfunction

        function void set_pattern(slpc_pkg::mode_t m, int r, int g, int b,
                                  int on_t, int off_t);
            mode   = m;
            red    = slpc_pkg::LEVEL_W'(r);
            green  = slpc_pkg::LEVEL_W'(g);
            blue   = slpc_pkg::LEVEL_W'(b);
            on_ms  = slpc_pkg::TIME_W'(on_t);
            off_ms = slpc_pkg::TIME_W'(off_t);
        endfunction

        function int pending();
            return shown_q.size();
        endfunction

        function void note_cmd(cmd_t c);
            int unsigned limit;
            int unsigned last;
            led_result_t exp;
            cmds_seen++;
            case (c.kind)
                slpc_pkg::KIND_TICK:
                begin
                    if (ovr != slpc_pkg::OVR_NONE)
                    begin
                        if (ovr == slpc_pkg::OVR_SUCCESS)
                        begin
                            limit = (seg == 0) ? 32'(slpc_pkg::SHORT_MS)
                                               : 32'(slpc_pkg::LONG_MS);
                            last  = 1;
                        end
                        else
                        begin
                            limit = 32'(slpc_pkg::ERR_SEG_MS);
                            last  = 32'(N_FLASHES - 1);
                        end
                        ovr_ms++;
                        if (ovr_ms >= limit)
                        begin
                            ovr_ms = 0;
                            if (seg >= last)
                            begin
                                ovr = slpc_pkg::OVR_NONE;
                                seg = 0;
                                restart_blink();
                                overrides_done++;
                            end
                            else
                            begin
                                seg = (seg + 1) & 7;
                            end
                        end
                    end
                    else if (mode == slpc_pkg::MODE_BLINK && on_ms != 0 && off_ms != 0)
                    begin
                        phase_ms++;
                        if (phase_ms >= (off_phase ? off_ms : on_ms))
                        begin
                            phase_ms  = 0;
                            off_phase = !off_phase;
                            phase_flips++;
                        end
                    end
                end
                slpc_pkg::KIND_STATUS:
                begin
                    case (c.code)
                        slpc_pkg::ST_AP:
                            set_pattern(slpc_pkg::MODE_BLINK, 0, 0, 30, 1000, 1000);
                        slpc_pkg::ST_CONNECTING:
                            set_pattern(slpc_pkg::MODE_BLINK, 30, 20, 0, 200, 200);
                        slpc_pkg::ST_NORMAL:
                            set_pattern(slpc_pkg::MODE_SOLID, 0, 25, 0, 0, 0);
                        slpc_pkg::ST_REQUEST:
                            set_pattern(slpc_pkg::MODE_BLINK, 0, 20, 30, 150, 150);
                        slpc_pkg::ST_RESET_WARN:
                            set_pattern(slpc_pkg::MODE_BLINK, 40, 0, 0, 100, 100);
                        slpc_pkg::ST_FACTORY:
                            set_pattern(slpc_pkg::MODE_SOLID, 40, 0, 0, 0, 0);
                        default: ;
                    endcase
                    restart_blink();
                end
                slpc_pkg::KIND_SUCCESS, slpc_pkg::KIND_ERROR:
                begin
                    ovr    = (c.kind == slpc_pkg::KIND_SUCCESS) ? slpc_pkg::OVR_SUCCESS
                                                                : slpc_pkg::OVR_ERROR;
                    seg    = 0;
                    ovr_ms = 0;
                end
                slpc_pkg::KIND_BLINK:
                begin
                    mode   = slpc_pkg::MODE_BLINK;
                    on_ms  = c.on_ms;
                    off_ms = c.off_ms;
                    restart_blink();
                end
                slpc_pkg::KIND_COLOR:
                begin
                    set_pattern(slpc_pkg::MODE_SOLID, c.red, c.green, c.blue, 0, 0);
                    restart_blink();
                end
                slpc_pkg::KIND_OFF:
                begin
                    set_pattern(slpc_pkg::MODE_OFF, 0, 0, 0, 0, 0);
                    restart_blink();
                end
                default: ;
            endcase

            exp = '0;
            exp.busy = (ovr != slpc_pkg::OVR_NONE);
            if (ovr == slpc_pkg::OVR_SUCCESS)
            begin
                if (seg != 0)
                    exp.green = slpc_pkg::FLASH_LEVEL;
            end
            else if (ovr == slpc_pkg::OVR_ERROR)
            begin
                if (ovr_ms < slpc_pkg::SHORT_MS)
                    exp.red = slpc_pkg::FLASH_LEVEL;
            end
            else if (mode == slpc_pkg::MODE_SOLID ||
                     (mode == slpc_pkg::MODE_BLINK && on_ms != 0 &&
                      (off_ms == 0 || !off_phase)))
            begin
                exp.red   = red;
                exp.green = green;
                exp.blue  = blue;
            end
            shown_q.push_back(exp);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("tb: mismatch at %0t: %s", $time, what);
        endfunction

        function void check_led(led_result_t got);
            led_result_t exp;
            checked++;
            if (shown_q.size() == 0)
            begin
                report($sformatf("unexpected LED result r=%0d g=%0d b=%0d busy=%0b",
                                 got.red, got.green, got.blue, got.busy));
                return;
            end
            exp = shown_q.pop_front();
            if (got.red !== exp.red || got.green !== exp.green ||
                got.blue !== exp.blue || got.busy !== exp.busy)
                report($sformatf({"expected r=%0d g=%0d b=%0d busy=%0b, ",
                                  "got r=%0d g=%0d b=%0d busy=%0b"},
                                 exp.red, exp.green, exp.blue, exp.busy,
                                 got.red, got.green, got.blue, got.busy));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_asked;
    int   hold_done = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    led_state_tracker book;

    slpc_cmd_if cmd();
    slpc_led_if led();

    status_led_pattern_controller_core #(
        .ERROR_FLASHES(N_FLASHES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .led   (led)
    );

    always #5 clk = ~clk;

    function automatic cmd_t make_cmd(int kind, int code, int r, int g, int b,
                                      int on_t, int off_t);
        cmd_t c;
        c.kind   = slpc_pkg::KIND_W'(kind);
        c.code   = slpc_pkg::CODE_W'(code);
        c.red    = slpc_pkg::LEVEL_W'(r);
        c.green  = slpc_pkg::LEVEL_W'(g);
        c.blue   = slpc_pkg::LEVEL_W'(b);
        c.on_ms  = slpc_pkg::TIME_W'(on_t);
        c.off_ms = slpc_pkg::TIME_W'(off_t);
        return c;
    endfunction

    function automatic cmd_t random_cmd(int tick_pct, bit allow_signal);
        cmd_t c;
        int   pick;
        c = make_cmd(slpc_pkg::KIND_TICK, $urandom_range(7), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        if ($urandom_range(99) < tick_pct)
            return c;
        pick = $urandom_range(allow_signal ? 7 : 5);
        case (pick)
            0, 5: c.kind = slpc_pkg::KIND_STATUS;
            1:
            begin
                c.kind = slpc_pkg::KIND_BLINK;
                if ($urandom_range(3) != 0)
                begin
                    c.on_ms  = slpc_pkg::TIME_W'($urandom_range(6));
                    c.off_ms = slpc_pkg::TIME_W'($urandom_range(6));
                end
            end
            2: c.kind = slpc_pkg::KIND_COLOR;
            3: c.kind = slpc_pkg::KIND_OFF;
            4: c.kind = KIND_UNUSED;
            6: c.kind = slpc_pkg::KIND_SUCCESS;
            default: c.kind = slpc_pkg::KIND_ERROR;
        endcase
        return c;
    endfunction

    task automatic send_cmd(cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd.valid = 1'b0;
            @(negedge clk);
        end
        cmd.valid       = 1'b1;
        cmd.kind        = c.kind;
        cmd.status_code = c.code;
        cmd.red_in      = c.red;
        cmd.green_in    = c.green;
        cmd.blue_in     = c.blue;
        cmd.on_time     = c.on_ms;
        cmd.off_time    = c.off_ms;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic run_override(logic [2:0] which);
        int   need;
        int   ticks;
        cmd_t c;
        need  = ((which == slpc_pkg::KIND_SUCCESS)
                 ? int'(slpc_pkg::SHORT_MS) + int'(slpc_pkg::LONG_MS)
                 : int'(slpc_pkg::ERR_SEG_MS) * N_FLASHES) + 20;
        ticks = 0;
        send_cmd(make_cmd(which, 0, 0, 0, 0, 0, 0));
        while (ticks < need)
        begin
            c = random_cmd(95, 1'b0);
            send_cmd(c);
            if (c.kind == slpc_pkg::KIND_TICK)
                ticks++;
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            led.ready = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            led.ready = 1'b0;
        end
        else if (hold_asked != hold_done)
        begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            led.ready = 1'b0;
        end
        else
        begin
            led.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        cmd_t        c;
        led_result_t r;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                c = make_cmd(cmd.kind, cmd.status_code, cmd.red_in, cmd.green_in,
                             cmd.blue_in, cmd.on_time, cmd.off_time);
                book.note_cmd(c);
            end
            if (led.valid && led.ready)
            begin
                r.red   = led.red_out;
                r.green = led.green_out;
                r.blue  = led.blue_out;
                r.busy  = led.override_busy;
                book.check_led(r);
            end
            if ((cmd.valid && cmd.ready) || (led.valid && led.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        book            = new();
        rst_n           = 1'b0;
        src_idle_pct    = 0;
        snk_idle_pct    = 0;
        hold_asked      = 0;
        cmd.valid       = 1'b0;
        cmd.kind        = slpc_pkg::KIND_TICK;
        cmd.status_code = '0;
        cmd.red_in      = '0;
        cmd.green_in    = '0;
        cmd.blue_in     = '0;
        cmd.on_time     = '0;
        cmd.off_time    = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_cmd(make_cmd(KIND_UNUSED, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        for (int code = 0; code < 8; code++)
            send_cmd(make_cmd(slpc_pkg::KIND_STATUS, code, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_COLOR, 0, 8'hff, 8'hff, 8'hff, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_COLOR, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_BLINK, 0, 0, 0, 0, 16'd0, 16'd3));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_BLINK, 0, 0, 0, 0, 16'd3, 16'd0));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_BLINK, 0, 0, 0, 0, 16'hffff, 16'hffff));
        send_cmd(make_cmd(slpc_pkg::KIND_BLINK, 0, 0, 0, 0, 16'd1, 16'd1));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_SUCCESS, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_COLOR, 0, 8'd12, 8'd200, 8'd77, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_OFF, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_UNUSED, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(slpc_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 74 : 0;
            snk_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 6 : 0;
            for (int n = 0; n < PER_PHASE; n++)
            begin
                send_cmd(random_cmd(70, 1'b1));
                if (ph == 2 && n == 10)
                    hold_asked++;
            end
            if (ph == 0)
                run_override(slpc_pkg::KIND_ERROR);
            else if (ph == 1)
                run_override(slpc_pkg::KIND_SUCCESS);
        end

        @(negedge clk);
        cmd.valid = 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d commands predicted, %0d LED results checked, %0d mismatches",
                 book.cmds_seen, book.checked, book.mismatches);
        $display("tb: %0d override sequences ran to the end, %0d blink phase changes",
                 book.overrides_done, book.phase_flips);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
